[sv/uav_pkg.sv]
// shared types, constants and character class helpers for the url authority validator
// no dependencies; used by uav_core, url_authority_validator_unit and the testbench
package uav_pkg;

    // length limits of a hostname and of one of its labels
    localparam logic [7:0] HOST_LENGTH_LIMIT  = 8'd253;
    localparam logic [6:0] LABEL_LENGTH_LIMIT = 7'd63;

    // largest port value and the most port digits allowed
    localparam logic [16:0] PORT_MAX        = 17'd65535;
    localparam logic [2:0]  PORT_DIGITS_MAX = 3'd5;

    // characters with a role of their own
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // parse phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_HOST   = 3'd1;
    localparam logic [2:0] PH_LIT    = 3'd2;
    localparam logic [2:0] PH_CLOSED = 3'd3;
    localparam logic [2:0] PH_PORT_H = 3'd4;
    localparam logic [2:0] PH_PORT_L = 3'd5;
    localparam logic [2:0] PH_ERR_H  = 3'd6;
    localparam logic [2:0] PH_ERR_L  = 3'd7;

    // verdict for one authority
    typedef struct packed {
        logic [15:0] port_number;
        logic        has_port;
        logic        is_literal;
        logic        accepted;
    } t_verdict;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

[sv/uav_core.sv]
// running parse state of one authority and the verdict logic
// depends on uav_pkg
module uav_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,     // one request moves through this cycle
    input  logic [7:0]        i_char,
    input  logic              i_last,
    input  logic              i_none,
    output uav_pkg::t_verdict o_verdict   // valid in the cycle of a last request
);

    logic [2:0]  r_phase,      n_phase;
    logic [7:0]  r_host_len,   n_host_len;
    logic [6:0]  r_label_len,  n_label_len;
    logic        r_prev_alnum, n_prev_alnum;
    logic [16:0] r_port_acc,   n_port_acc;
    logic [2:0]  r_port_cnt,   n_port_cnt;
    logic        r_lit_colon,  n_lit_colon;
    logic        r_lit_nonempty, n_lit_nonempty;

    logic        host_room;
    logic        label_room;
    logic        label_open;
    logic        digit_ok;
    logic [16:0] port_next;
    logic        fin_lit;
    logic        fin_port;
    logic        fin_acc;

    assign host_room  = r_host_len < uav_pkg::HOST_LENGTH_LIMIT;
    assign label_room = r_label_len < uav_pkg::LABEL_LENGTH_LIMIT;
    assign label_open = (r_label_len != 7'd0) && r_prev_alnum;
    assign digit_ok   = uav_pkg::is_digit(i_char) && (r_port_cnt < uav_pkg::PORT_DIGITS_MAX);
    // acc * 10 + digit
    assign port_next  = (r_port_acc << 3) + (r_port_acc << 1)
                      + {9'd0, i_char - uav_pkg::CH_ZERO};

    always_comb begin
        n_phase        = r_phase;
        n_host_len     = r_host_len;
        n_label_len    = r_label_len;
        n_prev_alnum   = r_prev_alnum;
        n_port_acc     = r_port_acc;
        n_port_cnt     = r_port_cnt;
        n_lit_colon    = r_lit_colon;
        n_lit_nonempty = r_lit_nonempty;

        if (!i_none) begin
            unique case (r_phase)
                uav_pkg::PH_START, uav_pkg::PH_HOST: begin
                    if ((r_phase == uav_pkg::PH_START) && (i_char == uav_pkg::CH_OPEN)) begin
                        n_phase = uav_pkg::PH_LIT;
                    end else if (uav_pkg::is_alnum(i_char)) begin
                        n_prev_alnum = 1'b1;
                        n_host_len   = r_host_len + 8'd1;
                        n_label_len  = r_label_len + 7'd1;
                        n_phase = (host_room && label_room) ? uav_pkg::PH_HOST
                                                            : uav_pkg::PH_ERR_H;
                    end else if (i_char == uav_pkg::CH_DASH) begin
                        n_prev_alnum = 1'b0;
                        n_host_len   = r_host_len + 8'd1;
                        n_label_len  = r_label_len + 7'd1;
                        n_phase = ((r_label_len != 7'd0) && host_room && label_room)
                                ? uav_pkg::PH_HOST : uav_pkg::PH_ERR_H;
                    end else if (i_char == uav_pkg::CH_DOT) begin
                        n_prev_alnum = 1'b0;
                        n_label_len  = 7'd0;
                        n_host_len   = r_host_len + 8'd1;
                        n_phase = (label_open && host_room) ? uav_pkg::PH_HOST
                                                            : uav_pkg::PH_ERR_H;
                    end else if (i_char == uav_pkg::CH_COLON) begin
                        n_phase = label_open ? uav_pkg::PH_PORT_H : uav_pkg::PH_ERR_H;
                    end else begin
                        n_phase = uav_pkg::PH_ERR_H;
                    end
                end
                uav_pkg::PH_LIT: begin
                    if (i_char == uav_pkg::CH_CLOSE) begin
                        n_phase = (r_lit_nonempty && r_lit_colon) ? uav_pkg::PH_CLOSED
                                                                  : uav_pkg::PH_ERR_L;
                    end else if (uav_pkg::is_hex(i_char) || (i_char == uav_pkg::CH_COLON)
                                 || (i_char == uav_pkg::CH_DOT)) begin
                        n_lit_nonempty = 1'b1;
                        if (i_char == uav_pkg::CH_COLON) begin
                            n_lit_colon = 1'b1;
                        end
                    end else begin
                        n_phase = uav_pkg::PH_ERR_L;
                    end
                end
                uav_pkg::PH_CLOSED: begin
                    n_phase = (i_char == uav_pkg::CH_COLON) ? uav_pkg::PH_PORT_L
                                                            : uav_pkg::PH_ERR_L;
                end
                uav_pkg::PH_PORT_H, uav_pkg::PH_PORT_L: begin
                    if (digit_ok) begin
                        n_port_acc = port_next;
                        n_port_cnt = r_port_cnt + 3'd1;
                    end else begin
                        n_phase = (r_phase == uav_pkg::PH_PORT_H) ? uav_pkg::PH_ERR_H
                                                                  : uav_pkg::PH_ERR_L;
                    end
                end
                default: begin
                    // error phases swallow bytes until the last one
                end
            endcase
        end
    end

    // verdict on the state after this request's byte
    always_comb begin
        fin_lit  = (n_phase == uav_pkg::PH_LIT) || (n_phase == uav_pkg::PH_CLOSED)
                || (n_phase == uav_pkg::PH_PORT_L) || (n_phase == uav_pkg::PH_ERR_L);
        fin_port = (n_phase == uav_pkg::PH_PORT_H) || (n_phase == uav_pkg::PH_PORT_L);
        priority if (n_phase == uav_pkg::PH_HOST) begin
            fin_acc = (n_label_len != 7'd0) && n_prev_alnum;
        end else if (n_phase == uav_pkg::PH_CLOSED) begin
            fin_acc = 1'b1;
        end else if (fin_port) begin
            fin_acc = (n_port_cnt != 3'd0) && (n_port_acc != 17'd0)
                   && (n_port_acc <= uav_pkg::PORT_MAX);
        end else begin
            fin_acc = 1'b0;
        end
        o_verdict.accepted    = fin_acc;
        o_verdict.is_literal  = fin_lit;
        o_verdict.has_port    = fin_acc && fin_port;
        o_verdict.port_number = (fin_acc && fin_port) ? n_port_acc[15:0] : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase        <= uav_pkg::PH_START;
            r_host_len     <= 8'd0;
            r_label_len    <= 7'd0;
            r_prev_alnum   <= 1'b0;
            r_port_acc     <= 17'd0;
            r_port_cnt     <= 3'd0;
            r_lit_colon    <= 1'b0;
            r_lit_nonempty <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_host_len     <= n_host_len;
            r_label_len    <= n_label_len;
            r_prev_alnum   <= n_prev_alnum;
            r_port_acc     <= n_port_acc;
            r_port_cnt     <= n_port_cnt;
            r_lit_colon    <= n_lit_colon;
            r_lit_nonempty <= n_lit_nonempty;
        end
    end

endmodule

[sv/url_authority_validator_unit.sv]
// top level of the url authority validator: stream ports, input and result registers
// depends on uav_pkg and uav_core
//
// Checks a URL authority (a hostname of dot-separated labels, or a bracketed
// literal of hex digits, colons and dots holding a colon, either optionally
// followed by ':' and a port 1..65535) fed one byte per request, and returns
// one verdict request on the master side for each request that carries tlast.
// Requests without tlast produce nothing on the output. A request with tuser
// set carries no byte; it serves for an empty authority or to close a run.
// The block takes one request per cycle with no bubbles unless throttled as
// below: a byte sits in the input register, the running parse state and the
// verdict are worked out combinationally from it, and the verdict lands in
// the result register. The only thing that throttles the input is a verdict
// that waits on master tready while another last byte is ready to finish;
// plain bytes keep flowing.
module url_authority_validator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // final_item
    input  logic        s_axis_tuser,   // no_character
    // verdict requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] accepted, [1] is_literal, [2] has_port,
                                        // [18:3] port_number, [23:19] zero
);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_last;
    logic              r_in_none;

    // result register
    logic              r_out_valid;
    uav_pkg::t_verdict r_out;

    uav_pkg::t_verdict verdict;
    logic              advance;

    // a plain byte always moves on; a last byte needs room in the result register
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    uav_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .i_none    (r_in_none),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
            r_in_none <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.port_number, r_out.has_port,
                            r_out.is_literal, r_out.accepted};

endmodule

[tb/sv/url_authority_checker.sv]
// checker for the url authority validator: watches both stream channels, predicts each verdict
// and compares it field by field; depends on uav_pkg for the verdict type and character codes
module url_authority_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,     // [7:0] character
    input  logic        i_in_tlast,     // final_item
    input  logic        i_in_tuser,     // no_character
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [23:0] i_out_tdata,    // [0] accepted, [1] is_literal, [2] has_port,
                                        // [18:3] port_number, [23:19] zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_verdict_count,
    output int          o_accepted_count,
    output int          o_port_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import uav_pkg::*;

    typedef logic [7:0] char_t;

    // running parse state of the authority under way
    logic [2:0]  phase;
    logic [7:0]  host_len;
    logic [6:0]  label_len;
    logic        prev_alnum;
    logic [16:0] port_acc;
    logic [2:0]  port_digits;
    logic        lit_colon;
    logic        lit_nonempty;

    t_verdict verdict_q[$];
    int       fail_total     = 0;
    int       verdict_total  = 0;
    int       accepted_total = 0;
    int       port_total     = 0;

    assign o_fail_count     = fail_total;
    assign o_verdict_count  = verdict_total;
    assign o_accepted_count = accepted_total;
    assign o_port_count     = port_total;

    function automatic bit digit_chr(input char_t c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit alnum_chr(input char_t c);
        return digit_chr(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit hex_chr(input char_t c);
        return digit_chr(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    task automatic clear_parse();
        phase        = PH_START;
        host_len     = '0;
        label_len    = '0;
        prev_alnum   = 1'b0;
        port_acc     = '0;
        port_digits  = '0;
        lit_colon    = 1'b0;
        lit_nonempty = 1'b0;
    endtask

    // one more host character, and one more label character when in_label
    task automatic count_host_char(input bit in_label, output bit ok);
        ok = 1'b0;
        if (host_len < HOST_LENGTH_LIMIT) begin
            host_len = host_len + 8'd1;
            if (!in_label) begin
                ok = 1'b1;
            end else if (label_len < LABEL_LENGTH_LIMIT) begin
                label_len = label_len + 7'd1;
                ok = 1'b1;
            end
        end
    endtask

    task automatic host_char(input char_t c);
        bit ok;
        bit to_port;
        ok = 1'b0;
        to_port = 1'b0;
        if (alnum_chr(c)) begin
            count_host_char(1'b1, ok);
            prev_alnum = 1'b1;
        end else if (c == CH_DASH) begin
            if (label_len != 0) count_host_char(1'b1, ok);
            prev_alnum = 1'b0;
        end else if (c == CH_DOT) begin
            if (label_len != 0 && prev_alnum) count_host_char(1'b0, ok);
            label_len  = '0;
            prev_alnum = 1'b0;
        end else if (c == CH_COLON) begin
            to_port = label_len != 0 && prev_alnum;
        end
        if (to_port) phase = PH_PORT_H;
        else phase = ok ? PH_HOST : PH_ERR_H;
    endtask

    task automatic port_char(input char_t c, input logic [2:0] bad_phase);
        if (!digit_chr(c) || port_digits >= PORT_DIGITS_MAX) begin
            phase = bad_phase;
        end else begin
            port_acc    = port_acc * 17'd10 + 17'(c - CH_ZERO);
            port_digits = port_digits + 3'd1;
        end
    endtask

    task automatic parse_request(input char_t c, input bit fin, input bit none);
        t_verdict v;
        bit       lit;
        bit       in_port;
        bit       ok;
        if (!none) begin
            case (phase)
                PH_START: begin
                    if (c == CH_OPEN) phase = PH_LIT;
                    else host_char(c);
                end
                PH_HOST: host_char(c);
                PH_LIT: begin
                    if (c == CH_CLOSE) begin
                        phase = (lit_nonempty && lit_colon) ? PH_CLOSED : PH_ERR_L;
                    end else if (hex_chr(c) || c == CH_COLON || c == CH_DOT) begin
                        lit_nonempty = 1'b1;
                        if (c == CH_COLON) lit_colon = 1'b1;
                    end else begin
                        phase = PH_ERR_L;
                    end
                end
                PH_CLOSED: phase = (c == CH_COLON) ? PH_PORT_L : PH_ERR_L;
                PH_PORT_H: port_char(c, PH_ERR_H);
                PH_PORT_L: port_char(c, PH_ERR_L);
                default: ;
            endcase
        end
        if (fin) begin
            lit = phase == PH_LIT || phase == PH_CLOSED || phase == PH_PORT_L || phase == PH_ERR_L;
            in_port = phase == PH_PORT_H || phase == PH_PORT_L;
            ok = 1'b0;
            if (phase == PH_HOST) ok = label_len != 0 && prev_alnum;
            else if (phase == PH_CLOSED) ok = 1'b1;
            else if (in_port) ok = port_digits != 0 && port_acc >= 17'd1 && port_acc <= PORT_MAX;
            v.accepted    = ok;
            v.is_literal  = lit;
            v.has_port    = ok && in_port;
            v.port_number = (ok && in_port) ? port_acc[15:0] : 16'd0;
            verdict_q.push_back(v);
            clear_parse();
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_verdict();
        t_verdict want;
        t_verdict got;
        got = i_out_tdata[18:0];
        if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual %h", $time, got);
            fail_total++;
        end else begin
            want = verdict_q.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("is_literal", want.is_literal, got.is_literal);
            compare_field("has_port", want.has_port, got.has_port);
            compare_field("port_number", want.port_number, got.port_number);
            verdict_total++;
            if (want.accepted) accepted_total++;
            if (want.has_port) port_total++;
        end
    endtask

    // a verdict taken at this edge comes from a request taken at an earlier one,
    // so the output side is handled first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            verdict_q.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) check_verdict();
            if (i_in_tvalid && i_in_tready) parse_request(i_in_tdata, i_in_tlast, i_in_tuser);
        end
        o_pending = verdict_q.size();
    end

endmodule

[tb/sv/url_authority_validator_unit_tb.sv]
// testbench top for url_authority_validator_unit: clock, reset, authority stimulus and verdict
// depends on uav_pkg, url_authority_validator_unit and url_authority_checker
module url_authority_validator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] character
    logic        s_axis_tlast;     // final_item
    logic        s_axis_tuser;     // no_character
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;     // [0] accepted, [1] is_literal, [2] has_port,
                                   // [18:3] port_number, [23:19] zero

    int fail_count;
    int pending;
    int verdict_count;
    int accepted_count;
    int port_count;

    // requests that carry a byte or close an authority; ignored requests are not counted
    int    request_count = 0;
    // no random idling on either side while set
    bit    quiet = 1'b0;
    // bytes of the authority being built
    t_char auth_q[$];

    always #5 i_clk = ~i_clk;

    url_authority_validator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    url_authority_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_tvalid      (s_axis_tvalid),
        .i_in_tready      (s_axis_tready),
        .i_in_tdata       (s_axis_tdata),
        .i_in_tlast       (s_axis_tlast),
        .i_in_tuser       (s_axis_tuser),
        .i_out_tvalid     (m_axis_tvalid),
        .i_out_tready     (m_axis_tready),
        .i_out_tdata      (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_verdict_count  (verdict_count),
        .o_accepted_count (accepted_count),
        .o_port_count     (port_count)
    );

    // receiver stalls about 7 percent of the time unless quiet is set
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one request; returns at the edge where it was taken
    task automatic send_req(input t_char c, input bit last, input bit none);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= none;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (last || !none) request_count++;
    endtask

    // sends auth_q; the run ends on its last byte, or on a byteless request when
    // close_empty is set or the authority is empty
    task automatic send_auth(input bit close_empty);
        int k;
        for (k = 0; k < auth_q.size(); k++) begin
            // now and then a byteless request in the middle, which must change nothing
            if ($urandom_range(0, 99) < 4) send_req(t_char'($urandom), 1'b0, 1'b1);
            send_req(auth_q[k], (k == auth_q.size() - 1) && !close_empty, 1'b0);
        end
        if (close_empty || auth_q.size() == 0) send_req(t_char'($urandom), 1'b1, 1'b1);
    endtask

    // sender holds off until every verdict has come back
    task automatic drain();
        int cycles;
        cycles = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && cycles < 1000) begin
            @(posedge i_clk);
            cycles++;
        end
    endtask

    task automatic load_text(input string s);
        int k;
        auth_q.delete();
        for (k = 0; k < s.len(); k++) auth_q.push_back(s[k]);
    endtask

    function automatic t_char rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return t_char'(8'h30 + r);         // digit
        else if (r < 36) return t_char'(8'h61 + r - 10); // lower case
        else return t_char'(8'h41 + r - 36);             // upper case
    endfunction

    function automatic t_char rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return t_char'(8'h30 + r);
        else if (r < 16) return t_char'(8'h61 + r - 10);
        else return t_char'(8'h41 + r - 16);
    endfunction

    // a well-formed label: alnum at both ends, hyphens allowed inside
    task automatic add_label(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            if (k != 0 && k != len - 1 && $urandom_range(0, 4) == 0) begin
                auth_q.push_back(uav_pkg::CH_DASH);
            end else begin
                auth_q.push_back(rand_alnum());
            end
        end
    endtask

    // a well-formed hostname of exactly total characters
    task automatic add_host(input int total, input int max_label);
        int rem;
        int len;
        rem = total;
        while (rem > 0) begin
            len = $urandom_range(1, max_label);
            if (len > rem) len = rem;
            // never leave a single character for a dot with nothing after it
            if (rem - len == 1) len = (len > 1) ? len - 1 : len + 1;
            add_label(len);
            rem -= len;
            if (rem > 0) begin
                auth_q.push_back(uav_pkg::CH_DOT);
                rem--;
            end
        end
    endtask

    task automatic add_decimal(input int value);
        t_char digits[$];
        int    v;
        v = value;
        if (v == 0) digits.push_front(uav_pkg::CH_ZERO);
        while (v > 0) begin
            digits.push_front(t_char'(uav_pkg::CH_ZERO + v % 10));
            v = v / 10;
        end
        foreach (digits[k]) auth_q.push_back(digits[k]);
    endtask

    // colon and a port, mostly legal, with the edges of the port range mixed in
    task automatic add_port();
        int k;
        auth_q.push_back(uav_pkg::CH_COLON);
        case ($urandom_range(0, 11))
            0: ;                                  // colon with no digits
            1: add_decimal(0);
            2: add_decimal(65535);
            3: add_decimal(65536);
            4: add_decimal(99999);
            5: add_decimal(1);
            6: begin
                // leading zeros, possibly past the digit limit
                for (k = $urandom_range(1, 3); k > 0; k--) auth_q.push_back(uav_pkg::CH_ZERO);
                add_decimal($urandom_range(1, 999));
            end
            7: add_decimal($urandom_range(100000, 9999999));
            default: add_decimal($urandom_range(1, 65535));
        endcase
    endtask

    task automatic add_literal();
        int n;
        int k;
        auth_q.push_back(uav_pkg::CH_OPEN);
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                6, 7: auth_q.push_back(uav_pkg::CH_COLON);
                8: auth_q.push_back(uav_pkg::CH_DOT);
                9: auth_q.push_back(($urandom_range(0, 3) == 0) ? t_char'($urandom) : rand_hex());
                default: auth_q.push_back(rand_hex());
            endcase
        end
        if ($urandom_range(0, 1) == 0) begin
            auth_q.insert($urandom_range(1, auth_q.size()), uav_pkg::CH_COLON);
        end
        if ($urandom_range(0, 9) != 0) auth_q.push_back(uav_pkg::CH_CLOSE);
        if ($urandom_range(0, 2) == 0) add_port();
    endtask

    function automatic t_char odd_char();
        case ($urandom_range(0, 6))
            0: return t_char'($urandom);
            1: return uav_pkg::CH_DASH;
            2: return uav_pkg::CH_DOT;
            3: return uav_pkg::CH_COLON;
            4: return uav_pkg::CH_OPEN;
            5: return uav_pkg::CH_CLOSE;
            default: return t_char'($urandom_range(128, 255));
        endcase
    endfunction

    // a well-formed authority with one flaw worked in
    task automatic add_broken();
        int pos;
        if ($urandom_range(0, 3) == 0) add_literal();
        else add_host($urandom_range(1, 14), 6);
        if ($urandom_range(0, 1) == 0) add_port();
        pos = $urandom_range(0, auth_q.size() - 1);
        case ($urandom_range(0, 3))
            0: auth_q[pos] = odd_char();
            1: auth_q.push_back(($urandom_range(0, 1) == 0) ? uav_pkg::CH_DOT : uav_pkg::CH_DASH);
            2: auth_q.insert(pos, odd_char());
            default: auth_q.push_front(odd_char());
        endcase
    endtask

    initial begin
        int n_auth;
        int long_hosts;
        int pick;
        int k;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty authority, a byteless request inside a run, port at
        // both ends of its range, a bracketed literal, bad endings, a closing
        // byteless request after a trailing dot, a byte outside ascii
        auth_q.delete();
        send_auth(1'b0);
        send_req(t_char'($urandom), 1'b0, 1'b1);
        load_text("0");
        send_auth(1'b0);
        load_text("a:65535");
        send_auth(1'b0);
        load_text("[:]:1");
        send_auth(1'b0);
        load_text("a-");
        send_auth(1'b0);
        load_text("a.");
        send_auth(1'b1);
        auth_q.delete();
        auth_q.push_back(8'hFF);
        send_auth(1'b0);
        load_text("a:0");
        send_auth(1'b0);
        drain();

        // random authorities, mostly well formed, with noise and broken ones
        n_auth = 0;
        long_hosts = 0;
        while (request_count < 925) begin
            // a long stretch with no idling on either side
            quiet = n_auth >= 30 && n_auth < 45;
            if (n_auth % 25 == 12) drain();
            auth_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                add_host($urandom_range(1, 20), $urandom_range(1, 8));
                if ($urandom_range(0, 1) == 0) add_port();
            end else if (pick < 55) begin
                add_literal();
            end else if (pick < 75) begin
                add_broken();
            end else if (pick < 85) begin
                for (k = $urandom_range(1, 6); k > 0; k--) auth_q.push_back(t_char'($urandom));
            end else if (pick < 93) begin
                // labels around their length limit
                if ($urandom_range(0, 1) == 0) add_host($urandom_range(1, 5), 3);
                if (auth_q.size() != 0) auth_q.push_back(uav_pkg::CH_DOT);
                add_label($urandom_range(62, 65));
                if ($urandom_range(0, 2) == 0) add_port();
            end else if (pick < 96 && long_hosts < 2) begin
                // hostname exactly at the limit, then one past it
                add_host(253 + long_hosts, 63);
                if ($urandom_range(0, 1) == 0) add_port();
                long_hosts++;
            end else begin
                add_host($urandom_range(1, 10), 4);
                add_port();
            end
            send_auth($urandom_range(0, 99) < 15);
            n_auth++;
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (pending != 0) $display("%0t: %0d verdicts never arrived", $time, pending);
        $display("sent %0d requests in %0d authorities: hostnames, literals, ports, noise",
                 request_count, n_auth + 8);
        $display("checked %0d verdicts, %0d accepted, %0d with a port",
                 verdict_count, accepted_count, port_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
